FILE: rtl/pafd_pkg.sv
// Shared types and constants of the phi accrual failure detector.
package pafd_pkg;

  // Item function codes.
  localparam logic [1:0] FUNC_HEARTBEAT = 2'd0;
  localparam logic [1:0] FUNC_CHECK     = 2'd1;
  localparam logic [1:0] FUNC_INJECT    = 2'd2;
  localparam logic [1:0] FUNC_QUERY     = 2'd3;

  // Worker status codes.
  localparam logic [1:0] ST_ALIVE   = 2'd0;
  localparam logic [1:0] ST_SUSPECT = 2'd1;
  localparam logic [1:0] ST_FAILED  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_WORKER_COUNT = 3'd0;
  localparam logic [2:0] REG_LOCAL_ID     = 3'd1;
  localparam logic [2:0] REG_EXPECTED     = 3'd2;
  localparam logic [2:0] REG_TIMEOUT      = 3'd3;
  localparam logic [2:0] REG_Z_FAIL       = 3'd4;
  localparam logic [2:0] REG_Z_SUSPECT    = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Window geometry and the statistics cap on one interval.
  localparam int WIN_LEN   = 8;
  localparam int WIN_IDX_W = 3;
  localparam int ENTRY_W   = 24;
  localparam logic [ENTRY_W-1:0] ENTRY_CAP = '1;

  // Iteration counts of the shared shift-subtract unit.
  localparam logic [5:0] SQRT_STEPS = 6'd32;
  localparam logic [5:0] DIV_STEPS  = 6'd15;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } iter_op_t;

  // Control from the sequencer to the shift-subtract unit.
  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_ctl_t;

  // Status back from the shift-subtract unit.
  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } iter_stat_t;

endpackage

FILE: rtl/pafd_in_if.sv
// Input channel: one command word per handshake.
interface pafd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  worker;
  logic [31:0] now_ms;

  modport source (output valid, func, worker, now_ms, input ready);
  modport sink (input valid, func, worker, now_ms, output ready);
endinterface

FILE: rtl/pafd_out_if.sv
// Result channel: one report word per handshake.
interface pafd_out_if;
  logic              valid;
  logic              ready;
  logic [3:0]        worker_out;
  logic              known_worker;
  logic [1:0]        node_state;
  logic signed [15:0] z_score;
  logic              failure_event;
  logic              recovery_event;

  modport source (output valid, worker_out, known_worker, node_state, z_score,
                  failure_event, recovery_event, input ready);
  modport sink (input valid, worker_out, known_worker, node_state, z_score,
                failure_event, recovery_event, output ready);
endinterface

FILE: rtl/pafd_cfg_if.sv
// Configuration write channel: register index and data per word.
interface pafd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/pafd_iter_unit.sv
// Shared shift-subtract unit: integer square root and restoring division.
module pafd_iter_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  pafd_pkg::iter_ctl_t ctl,
  input  logic [63:0]         src_in,
  input  logic [35:0]         rem_in,
  input  logic [30:0]         divisor,
  output pafd_pkg::iter_stat_t stat
);
  import pafd_pkg::*;

  iter_op_t    op_r;
  logic [63:0] src_r;
  logic [35:0] rem_r;
  logic [31:0] acc_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [30:0] div_r;

  logic [35:0] shifted;
  logic [35:0] trial;
  logic        ge;

  // One step: bring in the next bits, compare with the trial value, subtract.
  always_comb begin
    if (op_r == OP_SQRT) begin
      shifted = {rem_r[33:0], src_r[63:62]};
      trial   = {2'b00, acc_r[31:0], 2'b01};
    end else begin
      shifted = {rem_r[34:0], src_r[63]};
      trial   = {5'b0, div_r};
    end
    ge = (shifted >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_SQRT;
    end else begin
      // Done pulses for one cycle after the last step.
      done_r <= !ctl.start && busy_r && (cnt_r == 6'd1);
      if (ctl.start) begin
        busy_r <= 1'b1;
        op_r   <= ctl.op;
        src_r  <= src_in;
        rem_r  <= rem_in;
        div_r  <= divisor;
        acc_r  <= '0;
        cnt_r  <= (ctl.op == OP_SQRT) ? SQRT_STEPS : DIV_STEPS;
      end else if (busy_r) begin
        rem_r <= ge ? (shifted - trial) : shifted;
        acc_r <= {acc_r[30:0], ge};
        src_r <= (op_r == OP_SQRT) ? {src_r[61:0], 2'b00} : {src_r[62:0], 1'b0};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat.done   = done_r;
  assign stat.result = acc_r;

endmodule

FILE: rtl/phi_accrual_failure_detector_unit.sv
// Top level of the phi accrual failure detector.
//
// Usage: commands enter on in_ch (func, worker, now_ms) and each gives exactly
// one report word on out_ch. Configuration words on cfg_ch are always taken
// (cfg ready is held high) and must only be sent while the block is idle.
// Heartbeat, inject and query words go from acceptance through the execute and
// push steps to a valid report. A check runs the window statistics through one
// multiplier and one shared shift-subtract unit: it decodes, reads eight window
// entries and sums them and their squares, forms the spread, takes the square
// root (one root bit per cycle), sets up and runs the division (one quotient bit
// per cycle) and finishes. A check with zero spread or a saturated score skips
// the division. A failed worker's check and unknown workers skip the statistics.
// One command is in flight at a time; in ready is high only while idle, from the
// cycle after the report is loaded. The report sits in an output register, so
// the next command is taken while the report still waits; a command's report is
// held back until the register frees. Reset (synchronous, active low) restores
// registers to their defaults and every worker to alive with an empty window,
// which reads as the expected interval.
module phi_accrual_failure_detector_unit #(
  parameter int MAX_WORKERS = 16
) (
  input logic        clk,
  input logic        rst_n,
  pafd_in_if.sink    in_ch,
  pafd_out_if.source out_ch,
  pafd_cfg_if.sink   cfg_ch
);
  import pafd_pkg::*;

  localparam int WIDX   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int ADDR_W = WIDX + WIN_IDX_W;
  localparam int DEPTH  = MAX_WORKERS * WIN_LEN;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_READ, S_SSQ, S_SPREAD, S_SQRT, S_DPREP, S_DIV, S_ZFIN, S_PUSH
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [4:0]         worker_count_r;
  logic [3:0]         local_id_r;
  logic [15:0]        expected_r;
  logic [28:0]        timeout_r;
  logic signed [15:0] z_fail_r;
  logic signed [15:0] z_suspect_r;

  // Per-worker records.
  logic [31:0]        last_seen_r [MAX_WORKERS];
  logic [2:0]         oldest_r    [MAX_WORKERS];
  logic [3:0]         fill_r      [MAX_WORKERS];
  logic               beaten_r    [MAX_WORKERS];
  logic [1:0]         status_r    [MAX_WORKERS];
  logic signed [15:0] zst_r       [MAX_WORKERS];

  // Interval window memory.
  logic [ENTRY_W-1:0] win_mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata;

  // Current item.
  logic [1:0]  func_r;
  logic [3:0]  worker_r;
  logic [31:0] now_r;
  logic        known_r;
  logic [WIDX-1:0] idx;

  // Statistics datapath.
  logic [3:0]          cnt_r;
  logic [2:0]          rd_slot_r;
  logic [26:0]         s_r;
  logic [51:0]         p_r;
  logic [53:0]         sq_r;
  logic [30:0]         d_r;
  logic [31:0]         elapsed_r;
  logic                neg_r;
  logic signed [15:0]  z_r;
  logic [26:0]         mul_a;
  logic [53:0]         mul_p;
  logic [ENTRY_W-1:0]  entry;
  logic [31:0]         interval;
  logic [54:0]         spread;
  logic [31:0]         elapsed_now;
  logic signed [36:0]  n_val;
  logic [36:0]         n_mag;
  logic [46:0]         a_val;
  logic                sat;

  // Result word waiting for the output register.
  logic [3:0]         res_worker_r;
  logic               res_known_r;
  logic [1:0]         res_state_r;
  logic signed [15:0] res_z_r;
  logic               res_fail_r;
  logic               res_rec_r;

  logic               out_valid_r;
  logic [3:0]         out_worker_r;
  logic               out_known_r;
  logic [1:0]         out_state_r;
  logic signed [15:0] out_z_r;
  logic               out_fail_r;
  logic               out_rec_r;

  iter_ctl_t   iter_ctl;
  iter_stat_t  iter_stat;
  logic [63:0] iter_src;
  logic [35:0] iter_rem;

  logic in_fire;
  logic out_free;
  logic is_beat;
  logic run_check;

  assign idx      = WIDX'(worker_r);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Decode of the current item for the execute step.
  assign is_beat   = known_r && (func_r == FUNC_HEARTBEAT);
  assign run_check = known_r && (func_r == FUNC_CHECK) && (status_r[idx] != ST_FAILED);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Window entry as seen by the statistics: unwritten slots read as expected.
  assign entry = (4'(rd_slot_r) < fill_r[idx]) ? rdata_r : ENTRY_W'(expected_r);

  // Interval since the last heartbeat, capped for storage.
  assign interval  = now_r - last_seen_r[idx];
  assign mem_wdata = (|interval[31:ENTRY_W]) ? ENTRY_CAP : interval[ENTRY_W-1:0];
  assign mem_we    = (state_r == S_EXEC) && known_r && (func_r == FUNC_HEARTBEAT)
                     && beaten_r[idx];
  assign mem_waddr = {idx, oldest_r[idx]};
  assign mem_raddr = {idx, cnt_r[2:0]};

  // Shared multiplier: entry squares during the read pass, then the sum squared.
  assign mul_a = (state_r == S_SSQ) ? s_r : 27'(entry);
  assign mul_p = mul_a * mul_a;

  // Spread = 8 * sum of squares - sum squared, which is 64 times the variance.
  assign spread = {p_r[51:0], 3'b000} - {1'b0, sq_r};

  // Normalized distance of elapsed time from the mean, scaled to Q8.8.
  assign elapsed_now = now_r - last_seen_r[idx];
  assign n_val = $signed({2'b00, elapsed_now, 3'b000}) - $signed({10'b0, s_r});
  assign n_mag = n_val[36] ? 37'(-n_val) : 37'(n_val);
  assign a_val = {n_mag[35:0], 11'b0};
  assign sat   = ({1'b0, a_val} >= {2'b00, d_r, 15'b0});

  // Operands of the shared unit.
  always_comb begin
    iter_ctl.start = 1'b0;
    iter_ctl.op    = OP_SQRT;
    iter_src       = {3'b000, spread, 6'b000000};
    iter_rem       = '0;
    if (state_r == S_SPREAD) begin
      iter_ctl.start = 1'b1;
    end else if (state_r == S_DPREP) begin
      iter_ctl.op    = OP_DIV;
      iter_ctl.start = (d_r != '0) && !sat;
      iter_src       = {a_val[14:0], 49'b0};
      iter_rem       = {4'b0000, a_val[46:15]};
    end
  end

  pafd_iter_unit u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (iter_ctl),
    .src_in  (iter_src),
    .rem_in  (iter_rem),
    .divisor (d_r),
    .stat    (iter_stat)
  );

  // Window memory, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= win_mem[mem_raddr];
  end

  // Sequencer, records, configuration and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      worker_count_r <= 5'd16;
      local_id_r     <= 4'd0;
      expected_r     <= 16'd100;
      timeout_r      <= 29'd1000;
      z_fail_r       <= 16'sd2048;
      z_suspect_r    <= 16'sd1024;
      out_valid_r    <= 1'b0;
      cnt_r          <= '0;
      for (int i = 0; i < MAX_WORKERS; i++) begin
        last_seen_r[i] <= '0;
        oldest_r[i]    <= '0;
        fill_r[i]      <= '0;
        beaten_r[i]    <= 1'b0;
        status_r[i]    <= ST_ALIVE;
        zst_r[i]       <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_WORKER_COUNT: worker_count_r <= cfg_ch.data[4:0];
          REG_LOCAL_ID:     local_id_r     <= cfg_ch.data[3:0];
          REG_EXPECTED:     expected_r     <= cfg_ch.data[15:0];
          REG_TIMEOUT:      timeout_r      <= cfg_ch.data[28:0];
          REG_Z_FAIL:       z_fail_r       <= $signed(cfg_ch.data[15:0]);
          REG_Z_SUSPECT:    z_suspect_r    <= $signed(cfg_ch.data[15:0]);
          default: ;
        endcase
      end

      // Output word: loaded from the push step, cleared once taken.
      if ((state_r == S_PUSH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            func_r   <= in_ch.func;
            worker_r <= in_ch.worker;
            now_r    <= in_ch.now_ms;
            known_r  <= ({1'b0, in_ch.worker} < worker_count_r)
                        && (32'(in_ch.worker) < 32'(MAX_WORKERS))
                        && (in_ch.worker != local_id_r);
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_worker_r <= worker_r;
          res_known_r  <= known_r;
          res_state_r  <= (known_r && !is_beat) ? status_r[idx] : ST_ALIVE;
          res_z_r      <= (known_r && !is_beat) ? zst_r[idx] : 16'sd0;
          res_fail_r   <= 1'b0;
          res_rec_r    <= is_beat && (status_r[idx] != ST_ALIVE);
          state_r      <= run_check ? S_READ : S_PUSH;
          if (known_r) begin
            case (func_r)
              FUNC_HEARTBEAT: begin
                if (beaten_r[idx]) begin
                  oldest_r[idx] <= oldest_r[idx] + 3'd1;
                  if (fill_r[idx] < 4'(WIN_LEN)) begin
                    fill_r[idx] <= fill_r[idx] + 4'd1;
                  end
                end
                last_seen_r[idx] <= now_r;
                beaten_r[idx]    <= 1'b1;
                status_r[idx]    <= ST_ALIVE;
                zst_r[idx]       <= '0;
              end
              FUNC_CHECK: begin
                cnt_r <= '0;
                s_r   <= '0;
                p_r   <= '0;
              end
              FUNC_INJECT: begin
                last_seen_r[idx] <= last_seen_r[idx]
                                    - ({timeout_r, 3'b000} + {2'b00, timeout_r, 1'b0});
              end
              default: ;
            endcase
          end
        end
        // Read pass: address, then entry sum and square, then square sum.
        S_READ: begin
          rd_slot_r <= cnt_r[2:0];
          cnt_r     <= cnt_r + 4'd1;
          if ((cnt_r >= 4'd1) && (cnt_r <= 4'd8)) begin
            s_r  <= s_r + 27'(entry);
            sq_r <= mul_p;
          end
          if (cnt_r >= 4'd2) begin
            p_r <= p_r + 52'(sq_r);
          end
          if (cnt_r == 4'd9) begin
            state_r <= S_SSQ;
          end
        end
        S_SSQ: begin
          sq_r    <= mul_p;
          state_r <= S_SPREAD;
        end
        S_SPREAD: begin
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (iter_stat.done) begin
            d_r     <= iter_stat.result[30:0];
            state_r <= S_DPREP;
          end
        end
        S_DPREP: begin
          elapsed_r <= elapsed_now;
          neg_r     <= n_val[36];
          if (d_r == '0) begin
            z_r     <= n_val[36] ? -16'sd32768 : ((n_val == '0) ? 16'sd0 : 16'sd32767);
            state_r <= S_ZFIN;
          end else if (sat) begin
            z_r     <= n_val[36] ? -16'sd32768 : 16'sd32767;
            state_r <= S_ZFIN;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (iter_stat.done) begin
            z_r     <= neg_r ? -$signed({1'b0, iter_stat.result[14:0]})
                             : $signed({1'b0, iter_stat.result[14:0]});
            state_r <= S_ZFIN;
          end
        end
        // Classify the worker from its score and the timeout.
        S_ZFIN: begin
          zst_r[idx] <= z_r;
          res_z_r    <= z_r;
          if ((z_r >= z_fail_r) || (elapsed_r > {3'b000, timeout_r})) begin
            status_r[idx] <= ST_FAILED;
            res_state_r   <= ST_FAILED;
            res_fail_r    <= 1'b1;
          end else if (z_r >= z_suspect_r) begin
            status_r[idx] <= ST_SUSPECT;
            res_state_r   <= ST_SUSPECT;
          end else begin
            status_r[idx] <= ST_ALIVE;
            res_state_r   <= ST_ALIVE;
          end
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (out_free) begin
            out_worker_r <= res_worker_r;
            out_known_r  <= res_known_r;
            out_state_r  <= res_state_r;
            out_z_r      <= res_z_r;
            out_fail_r   <= res_fail_r;
            out_rec_r    <= res_rec_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.worker_out     = out_worker_r;
  assign out_ch.known_worker   = out_known_r;
  assign out_ch.node_state     = out_state_r;
  assign out_ch.z_score        = out_z_r;
  assign out_ch.failure_event  = out_fail_r;
  assign out_ch.recovery_event = out_rec_r;

`ifndef NO_ASSERTIONS
  // An ignored item reports a neutral word.
  a_unknown_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_known_r |-> (out_state_r == ST_ALIVE) && (out_z_r == 16'sd0)
      && !out_fail_r && !out_rec_r)
    else $error("unknown worker report not neutral");

  // A recovery leaves the worker alive with a cleared score.
  a_recovery_alive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rec_r |-> (out_state_r == ST_ALIVE) && (out_z_r == 16'sd0)
      && !out_fail_r)
    else $error("recovery report inconsistent");

  // A failure event always reports the failed state.
  a_failure_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fail_r |-> (out_state_r == ST_FAILED) && out_known_r)
    else $error("failure event without failed state");
`endif

endmodule
